// ===== sv/psat_pkg.sv =====
// Shared types, constants and helper functions of the point-set affine transform.
package psat_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int CNT_W = 7;
	localparam int COORD_W = 32;
	localparam int SUM_W = 40;
	localparam int ANG_W = 26;
	localparam int CFG_IDX_W = 3;
	localparam int CRD_STEPS = 16;
	localparam int RES_W = 68;

	localparam logic signed [27:0] DEG90 = 28'sd5898240;
	localparam logic signed [27:0] DEG180 = 28'sd11796480;
	localparam logic signed [27:0] DEG360 = 28'sd23592960;
	localparam logic signed [32:0] CRD_GAIN = 33'sd652032874;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE = 3'd0,
		REG_PARAM_X = 3'd1,
		REG_PARAM_Y = 3'd2,
		REG_PARAM_Z = 3'd3,
		REG_PIVOT_X = 3'd4,
		REG_PIVOT_Y = 3'd5,
		REG_ANGLE = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_TRANSLATE = 2'd0,
		MODE_SCALE = 2'd1,
		MODE_ROT_PIVOT = 2'd2,
		MODE_ROT_CENTROID = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [COORD_W-1:0] param_x;
		logic signed [COORD_W-1:0] param_y;
		logic signed [COORD_W-1:0] param_z;
		logic signed [COORD_W-1:0] pivot_x;
		logic signed [COORD_W-1:0] pivot_y;
		logic signed [ANG_W-1:0] angle_deg;
	} cfg_t;

	// One collected object handed from the loader to the emitter.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic overflow;
	} job_t;

	// Arctangent of 2^-i in Q16.16 degrees.
	function automatic logic signed [27:0] atan_deg(input logic [3:0] i);
		logic signed [27:0] v;
		unique case (i)
			4'd0: v = 28'sd2949120;
			4'd1: v = 28'sd1740967;
			4'd2: v = 28'sd919879;
			4'd3: v = 28'sd466945;
			4'd4: v = 28'sd234379;
			4'd5: v = 28'sd117304;
			4'd6: v = 28'sd58666;
			4'd7: v = 28'sd29335;
			4'd8: v = 28'sd14668;
			4'd9: v = 28'sd7334;
			4'd10: v = 28'sd3667;
			4'd11: v = 28'sd1833;
			4'd12: v = 28'sd917;
			4'd13: v = 28'sd458;
			4'd14: v = 28'sd229;
			default: v = 28'sd115;
		endcase
		return v;
	endfunction

	// Clamp a wide signed result to signed 32 bits.
	function automatic logic [COORD_W-1:0] sat32(input logic signed [RES_W-1:0] v);
		logic [COORD_W-1:0] r;
		if (v > RES_W'(64'sh7FFFFFFF)) begin
			r = 32'h7FFFFFFF;
		end else if (v < -RES_W'(64'sh80000000)) begin
			r = 32'h80000000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/psat_if.sv =====
// Channel interfaces: input points, transformed points and register writes.
interface psat_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic in_last;
	modport source (output valid, output in_x, output in_y, output in_z, output in_last,
		input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, input in_last,
		output ready);
endinterface

interface psat_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic out_last;
	logic dropped;
	modport source (output valid, output out_x, output out_y, output out_z, output out_last,
		output dropped, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_last,
		input dropped, output ready);
endinterface

interface psat_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/psat_front.sv =====
// Loader: stores incoming points, keeps running sums and hands finished objects on.
module psat_front #(
	parameter int MAX_POINTS = 64
) (
	input logic clk,
	input logic arst_n,
	psat_in_if.sink pt_in,
	output psat_pkg::job_t job,
	output logic job_valid,
	input logic job_take,
	input logic done,
	input logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
	output logic [3*psat_pkg::COORD_W-1:0] rd_data
);
	import psat_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	logic [3*COORD_W-1:0] mem [MAX_POINTS];
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic signed [SUM_W-1:0] sx_q, sy_q, sz_q, sx_n, sy_n, sz_n;
	logic ovf_q, ovf_n, lock_q, job_vld_q, acc, full;
	job_t job_q;

	assign pt_in.ready = !lock_q;
	assign acc = pt_in.valid && !lock_q;
	assign full = (cnt_q == CNT_W'(MAX_POINTS));
	assign job = job_q;
	assign job_valid = job_vld_q;

	// Next count, sums and overflow flag after this transfer.
	always_comb begin
		cnt_n = cnt_q;
		sx_n = sx_q;
		sy_n = sy_q;
		sz_n = sz_q;
		ovf_n = ovf_q;
		if (full) begin
			ovf_n = 1'b1;
		end else begin
			cnt_n = cnt_q + 1'b1;
			sx_n = sx_q + SUM_W'(pt_in.in_x);
			sy_n = sy_q + SUM_W'(pt_in.in_y);
			sz_n = sz_q + SUM_W'(pt_in.in_z);
		end
	end

	// Collection state; locked from the last point until the emitter is finished.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			ovf_q <= 1'b0;
			lock_q <= 1'b0;
			job_vld_q <= 1'b0;
		end else begin
			if (done) begin
				lock_q <= 1'b0;
			end
			if (job_take) begin
				job_vld_q <= 1'b0;
			end
			if (acc) begin
				if (pt_in.in_last) begin
					cnt_q <= '0;
					sx_q <= '0;
					sy_q <= '0;
					sz_q <= '0;
					ovf_q <= 1'b0;
					lock_q <= 1'b1;
					job_vld_q <= 1'b1;
				end else begin
					cnt_q <= cnt_n;
					sx_q <= sx_n;
					sy_q <= sy_n;
					sz_q <= sz_n;
					ovf_q <= ovf_n;
				end
			end
		end
	end

	// Object descriptor held for the emitter.
	always_ff @(posedge clk) begin
		if (acc && pt_in.in_last) begin
			job_q <= '{count: cnt_n, sum_x: sx_n, sum_y: sy_n, sum_z: sz_n, overflow: ovf_n};
		end
	end

	// Point store with registered read.
	always_ff @(posedge clk) begin
		if (acc && !full) begin
			mem[cnt_q[AW-1:0]] <= {pt_in.in_x, pt_in.in_y, pt_in.in_z};
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/psat_back.sv =====
// Emitter: centroid divider, CORDIC sine and cosine, and the per-point transform.
module psat_back #(
	parameter int MAX_POINTS = 64
) (
	input logic clk,
	input logic arst_n,
	input psat_pkg::cfg_t cfg,
	input psat_pkg::job_t job,
	input logic job_valid,
	output logic job_take,
	output logic done,
	output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
	input logic [3*psat_pkg::COORD_W-1:0] rd_data,
	psat_out_if.source pt_out
);
	import psat_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CALC = 7'b0000010,
		S_RD = 7'b0000100,
		S_DIF = 7'b0001000,
		S_MUL = 7'b0010000,
		S_FIN = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t st_q;
	logic [5:0] step_q;
	logic [CNT_W-1:0] num_q, idx_q;
	logic ovf_q;
	logic [SUM_W-1:0] dq_q [3];
	logic [CNT_W:0] rm_q [3];
	logic neg_q [3];
	logic signed [27:0] ang_q, a1, a2;
	logic flip_q, flip_n;
	logic signed [32:0] crx_q, cry_q;
	logic signed [18:0] c16_q, s16_q;
	logic signed [32:0] cen_x_q, cen_y_q, cen_z_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [65:0] mxa_q, mxb_q, mya_q, myb_q, mz_q;
	logic [COORD_W-1:0] ox_q, oy_q, oz_q;
	logic olast_q;
	logic [1:0] mode;
	logic signed [32:0] cx_sel, cy_sel;
	logic signed [32:0] q_s [3];
	logic signed [32:0] crx_f, cry_f;
	logic signed [RES_W-1:0] rx, ry, rz;

	assign mode = cfg.mode;
	assign job_take = job_valid && (st_q == S_IDLE);
	assign rd_addr = idx_q[AW-1:0];
	assign pt_out.valid = (st_q == S_OUT);
	assign pt_out.out_x = ox_q;
	assign pt_out.out_y = oy_q;
	assign pt_out.out_z = oz_q;
	assign pt_out.out_last = olast_q;
	assign pt_out.dropped = ovf_q;
	assign done = (st_q == S_OUT) && pt_out.ready && olast_q;

	// Angle reduction into [-90, 90] with a sign flip.
	always_comb begin
		a1 = 28'(cfg.angle_deg);
		if (a1 > DEG180) begin
			a1 = a1 - DEG360;
		end else if (a1 < -DEG180) begin
			a1 = a1 + DEG360;
		end
		a2 = a1;
		flip_n = 1'b0;
		if (a1 > DEG90) begin
			a2 = a1 - DEG180;
			flip_n = 1'b1;
		end else if (a1 < -DEG90) begin
			a2 = a1 + DEG180;
			flip_n = 1'b1;
		end
	end

	// Signed centroid, rotation center and sign-corrected CORDIC outputs.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			q_s[l] = neg_q[l] ? -33'(dq_q[l]) : 33'(dq_q[l]);
		end
		cx_sel = (mode == MODE_ROT_PIVOT) ? 33'(cfg.pivot_x) : q_s[0];
		cy_sel = (mode == MODE_ROT_PIVOT) ? 33'(cfg.pivot_y) : q_s[1];
		crx_f = flip_q ? -crx_q : crx_q;
		cry_f = flip_q ? -cry_q : cry_q;
	end

	// Final add per mode, before saturation.
	always_comb begin
		unique case (mode)
			MODE_TRANSLATE: begin
				rx = RES_W'(px_q) + RES_W'(cfg.param_x);
				ry = RES_W'(py_q) + RES_W'(cfg.param_y);
				rz = RES_W'(pz_q) + RES_W'(cfg.param_z);
			end
			MODE_SCALE: begin
				rx = RES_W'(cen_x_q) + RES_W'(mxa_q >>> 16);
				ry = RES_W'(cen_y_q) + RES_W'(mya_q >>> 16);
				rz = RES_W'(cen_z_q) + RES_W'(mz_q >>> 16);
			end
			default: begin
				rx = RES_W'(cen_x_q) + RES_W'((RES_W'(mxa_q) + RES_W'(mxb_q)) >>> 16);
				ry = RES_W'(cen_y_q) + RES_W'((RES_W'(mya_q) - RES_W'(myb_q)) >>> 16);
				rz = RES_W'(pz_q);
			end
		endcase
	end

	// Sequencer: set-up iterations once per object, then one point at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			step_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						st_q <= S_CALC;
						step_q <= '0;
						idx_q <= '0;
					end
				end
				S_CALC: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'(SUM_W - 1)) begin
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_DIF;
				S_DIF: st_q <= S_MUL;
				S_MUL: st_q <= S_FIN;
				S_FIN: st_q <= S_OUT;
				S_OUT: begin
					if (pt_out.ready) begin
						if (olast_q) begin
							st_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q <= S_RD;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		logic [CNT_W:0] t;
		logic [3:0] i;
		t = '0;
		i = step_q[3:0];
		if (st_q == S_IDLE && job_valid) begin
			num_q <= job.count;
			ovf_q <= job.overflow;
			dq_q[0] <= job.sum_x[SUM_W-1] ? -job.sum_x : job.sum_x;
			dq_q[1] <= job.sum_y[SUM_W-1] ? -job.sum_y : job.sum_y;
			dq_q[2] <= job.sum_z[SUM_W-1] ? -job.sum_z : job.sum_z;
			neg_q[0] <= job.sum_x[SUM_W-1];
			neg_q[1] <= job.sum_y[SUM_W-1];
			neg_q[2] <= job.sum_z[SUM_W-1];
			for (int l = 0; l < 3; l++) begin
				rm_q[l] <= '0;
			end
			ang_q <= a2;
			flip_q <= flip_n;
			crx_q <= CRD_GAIN;
			cry_q <= '0;
		end
		if (st_q == S_CALC) begin
			// One quotient bit per lane per cycle.
			for (int l = 0; l < 3; l++) begin
				t = {rm_q[l][CNT_W-1:0], dq_q[l][SUM_W-1]};
				if (t >= {1'b0, num_q}) begin
					rm_q[l] <= t - {1'b0, num_q};
					dq_q[l] <= {dq_q[l][SUM_W-2:0], 1'b1};
				end else begin
					rm_q[l] <= t;
					dq_q[l] <= {dq_q[l][SUM_W-2:0], 1'b0};
				end
			end
			// CORDIC micro-rotation during the first steps.
			if (step_q < 6'(CRD_STEPS)) begin
				if (ang_q >= 0) begin
					crx_q <= crx_q - (cry_q >>> i);
					cry_q <= cry_q + (crx_q >>> i);
					ang_q <= ang_q - atan_deg(i);
				end else begin
					crx_q <= crx_q + (cry_q >>> i);
					cry_q <= cry_q - (crx_q >>> i);
					ang_q <= ang_q + atan_deg(i);
				end
			end
		end
		if (st_q == S_DIF) begin
			px_q <= rd_data[3*COORD_W-1:2*COORD_W];
			py_q <= rd_data[2*COORD_W-1:COORD_W];
			pz_q <= rd_data[COORD_W-1:0];
			cen_x_q <= cx_sel;
			cen_y_q <= cy_sel;
			cen_z_q <= q_s[2];
			dx_q <= 33'($signed(rd_data[3*COORD_W-1:2*COORD_W])) - cx_sel;
			dy_q <= 33'($signed(rd_data[2*COORD_W-1:COORD_W])) - cy_sel;
			dz_q <= 33'($signed(rd_data[COORD_W-1:0])) - q_s[2];
			c16_q <= 19'((crx_f + 33'sd8192) >>> 14);
			s16_q <= 19'((cry_f + 33'sd8192) >>> 14);
		end
		if (st_q == S_MUL) begin
			if (mode == MODE_SCALE) begin
				mxa_q <= 66'(dx_q) * 66'(cfg.param_x);
				mya_q <= 66'(dy_q) * 66'(cfg.param_y);
				mz_q <= 66'(dz_q) * 66'(cfg.param_z);
				mxb_q <= '0;
				myb_q <= '0;
			end else begin
				mxa_q <= 66'(dx_q) * 66'(c16_q);
				mxb_q <= 66'(dy_q) * 66'(s16_q);
				mya_q <= 66'(dy_q) * 66'(c16_q);
				myb_q <= 66'(dx_q) * 66'(s16_q);
				mz_q <= '0;
			end
		end
		if (st_q == S_FIN) begin
			ox_q <= sat32(rx);
			oy_q <= sat32(ry);
			oz_q <= sat32(rz);
			olast_q <= (idx_q + 1'b1 == num_q);
		end
	end

endmodule

// ===== sv/point_set_affine_transform_core.sv =====
// Point-set affine transform: top level with the register file, loader and emitter.
//
// Usage: points of one object arrive on pt_in as Q16.16 triples, at most one transfer
// per cycle. Each is stored and summed; the transfer with in_last set closes the object.
// Points beyond MAX_POINTS are discarded and reported by dropped on every result.
// After the last point the emitter runs the centroid divider (one quotient bit per
// cycle, CORDIC sine and cosine run alongside), then walks the store and presents
// the transformed points on pt_out one at a time, each through memory read,
// difference, multiply, add and saturate, output register. out_last marks the final one.
// While an object is being emitted pt_in.ready is low, since the store holds one object;
// it rises again in the cycle after the last result transfer.
// A receiver stall holds the current result in the output register and pauses the walk.
// Registers are written on cfg, always ready; index 7 is ignored. Writes must happen
// while the block is idle. Reset clears the registers, counts, sums and flags; the
// point store is not cleared and needs no pass.
module point_set_affine_transform_core #(
	parameter int MAX_POINTS = psat_pkg::MAX_POINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	psat_in_if.sink pt_in,
	psat_out_if.source pt_out,
	psat_cfg_if.sink cfg
);
	import psat_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

	cfg_t cfg_q;
	job_t job;
	logic job_valid, job_take, done;
	logic [AW-1:0] rd_addr;
	logic [3*COORD_W-1:0] rd_data;

	assign cfg.ready = 1'b1;

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE: cfg_q.mode <= cfg.data[1:0];
				REG_PARAM_X: cfg_q.param_x <= cfg.data;
				REG_PARAM_Y: cfg_q.param_y <= cfg.data;
				REG_PARAM_Z: cfg_q.param_z <= cfg.data;
				REG_PIVOT_X: cfg_q.pivot_x <= cfg.data;
				REG_PIVOT_Y: cfg_q.pivot_y <= cfg.data;
				REG_ANGLE: cfg_q.angle_deg <= cfg.data[ANG_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	psat_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_in),
		.job(job),
		.job_valid(job_valid),
		.job_take(job_take),
		.done(done),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	psat_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.job(job),
		.job_valid(job_valid),
		.job_take(job_take),
		.done(done),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.pt_out(pt_out)
	);

endmodule

// ===== bench/tb_point_set_affine_transform_core.sv =====
// Self-checking testbench of the point-set affine transform core.
module tb_point_set_affine_transform_core;
	import psat_pkg::*;

	typedef logic signed [95:0] wide_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic last;
	} point_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic last;
		logic dropped;
	} result_t;

	localparam int CAPACITY = 64;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam longint CRD_START = 652032874;
	localparam longint ONE_DEG = 65536;
	localparam longint ATAN_TAB [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
		58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

	logic clk;
	logic arst_n;

	psat_in_if pt_in ();
	psat_out_if pt_out ();
	psat_cfg_if cfg ();

	point_set_affine_transform_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pt_in(pt_in),
		.pt_out(pt_out),
		.cfg(cfg)
	);

	// Clock with an 8 unit period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Register copy and object state of the predictor.
	logic [1:0] cur_mode;
	logic signed [31:0] cur_param [3];
	logic signed [31:0] cur_pivot [2];
	logic signed [25:0] cur_angle;
	logic signed [31:0] obj_x [CAPACITY];
	logic signed [31:0] obj_y [CAPACITY];
	logic signed [31:0] obj_z [CAPACITY];
	int obj_count;
	longint obj_sum [3];
	logic obj_overflow;

	point_t point_queue [$];
	result_t expected_points [$];
	point_t cur_point;
	int send_idle;
	int recv_idle;
	int mismatches;
	int hold_left;
	bit hold_req;
	bit hold_ack;

	// Fixed-point sine and cosine of an angle in Q16.16 degrees.
	function automatic void sin_cos(input longint angle, output longint c, output longint s);
		longint a;
		longint x;
		longint y;
		longint t;
		bit flip;
		a = angle;
		x = CRD_START;
		y = 0;
		flip = 0;
		while (a > 180 * ONE_DEG) a -= 360 * ONE_DEG;
		while (a < -180 * ONE_DEG) a += 360 * ONE_DEG;
		if (a > 90 * ONE_DEG) begin
			a -= 180 * ONE_DEG;
			flip = 1;
		end else if (a < -90 * ONE_DEG) begin
			a += 180 * ONE_DEG;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			t = x;
			if (a >= 0) begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				a -= ATAN_TAB[i];
			end else begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				a += ATAN_TAB[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = (x + 8192) >>> 14;
		s = (y + 8192) >>> 14;
	endfunction

	function automatic logic [31:0] clamp32(input wide_t v);
		if (v > wide_t'(64'sh7FFFFFFF)) return 32'h7FFFFFFF;
		if (v < -wide_t'(64'sh80000000)) return 32'h80000000;
		return v[31:0];
	endfunction

	// Takes one accepted point; the last point of an object releases its results.
	task automatic take_point(input point_t p);
		wide_t ctr [3];
		wide_t pt [3];
		wide_t res [3];
		wide_t dx;
		wide_t dy;
		longint c16;
		longint s16;
		result_t r;
		if (obj_count < CAPACITY) begin
			obj_x[obj_count] = p.x;
			obj_y[obj_count] = p.y;
			obj_z[obj_count] = p.z;
			obj_sum[0] += p.x;
			obj_sum[1] += p.y;
			obj_sum[2] += p.z;
			obj_count++;
		end else begin
			obj_overflow = 1'b1;
		end
		if (!p.last) return;
		for (int a = 0; a < 3; a++) ctr[a] = obj_sum[a] / longint'(obj_count);
		c16 = 0;
		s16 = 0;
		if (mode_t'(cur_mode) == MODE_ROT_PIVOT) begin
			ctr[0] = cur_pivot[0];
			ctr[1] = cur_pivot[1];
		end
		if (cur_mode >= MODE_ROT_PIVOT) sin_cos(cur_angle, c16, s16);
		for (int k = 0; k < obj_count; k++) begin
			pt[0] = obj_x[k];
			pt[1] = obj_y[k];
			pt[2] = obj_z[k];
			case (mode_t'(cur_mode))
				MODE_TRANSLATE: begin
					for (int a = 0; a < 3; a++) res[a] = pt[a] + wide_t'(cur_param[a]);
				end
				MODE_SCALE: begin
					for (int a = 0; a < 3; a++)
						res[a] = ctr[a] + (((pt[a] - ctr[a]) * wide_t'(cur_param[a])) >>> 16);
				end
				default: begin
					dx = pt[0] - ctr[0];
					dy = pt[1] - ctr[1];
					res[0] = ctr[0] + ((dx * wide_t'(c16) + dy * wide_t'(s16)) >>> 16);
					res[1] = ctr[1] + ((dy * wide_t'(c16) - dx * wide_t'(s16)) >>> 16);
					res[2] = pt[2];
				end
			endcase
			r.x = clamp32(res[0]);
			r.y = clamp32(res[1]);
			r.z = clamp32(res[2]);
			r.last = (k + 1 == obj_count);
			r.dropped = obj_overflow;
			expected_points.push_back(r);
		end
		obj_count = 0;
		obj_sum = '{0, 0, 0};
		obj_overflow = 1'b0;
	endtask

	// Point driver: one transfer per accepted handshake, idling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pt_in.valid && pt_in.ready) take_point(cur_point);
			if (!pt_in.valid || pt_in.ready) begin
				if (point_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					cur_point = point_queue.pop_front();
					pt_in.valid <= 1'b1;
					pt_in.in_x <= cur_point.x;
					pt_in.in_y <= cur_point.y;
					pt_in.in_z <= cur_point.z;
					pt_in.in_last <= cur_point.last;
				end else begin
					pt_in.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready, with a long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_ack) begin
				hold_ack <= hold_req;
				hold_left <= 400;
				pt_out.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pt_out.ready <= 1'b0;
			end else begin
				pt_out.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Result checker against the oldest expected point.
	always @(posedge clk) begin
		result_t e;
		if (arst_n && pt_out.valid && pt_out.ready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer x=%h", pt_out.out_x);
			end else begin
				e = expected_points.pop_front();
				if (pt_out.out_x !== e.x || pt_out.out_y !== e.y || pt_out.out_z !== e.z ||
						pt_out.out_last !== e.last || pt_out.dropped !== e.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h last=%b drop=%b, got %h %h %h last=%b drop=%b",
							e.x, e.y, e.z, e.last, e.dropped, pt_out.out_x, pt_out.out_y,
							pt_out.out_z, pt_out.out_last, pt_out.dropped);
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_MODE: cur_mode = value[1:0];
			REG_PARAM_X: cur_param[0] = value;
			REG_PARAM_Y: cur_param[1] = value;
			REG_PARAM_Z: cur_param[2] = value;
			REG_PIVOT_X: cur_pivot[0] = value;
			REG_PIVOT_Y: cur_pivot[1] = value;
			REG_ANGLE: cur_angle = value[25:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_coord(input bit extreme);
		logic [31:0] edges [4] = '{32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF};
		case (extreme ? 3 : $urandom_range(3))
			0: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			1: return $urandom;
			2: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
			default: return edges[$urandom_range(3)];
		endcase
	endfunction

	task automatic queue_object(input int size, input bit extreme);
		point_t p;
		for (int i = 0; i < size; i++) begin
			p.x = pick_coord(extreme);
			p.y = pick_coord(extreme);
			p.z = pick_coord(extreme);
			p.last = (i == size - 1);
			point_queue.push_back(p);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (point_queue.size() != 0 || pt_in.valid || expected_points.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	// Parameter in Q16.16: for scaling mostly a factor within plus or minus four, else any coordinate value.
	function automatic logic [31:0] pick_param(input logic [1:0] m);
		if (m == MODE_SCALE && $urandom_range(3) != 0)
			return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		return pick_coord(0);
	endfunction

	// Phases of stimulus, each one setting the registers while the block is idle.
	initial begin
		logic [31:0] angles [8] = '{32'h0, 32'd23592960, -32'sd23592960, 32'd5898240,
			-32'sd5898240, 32'd11796480, 32'h01FF_FFFF, 32'h0200_0000};
		int phase;
		int size;
		logic [1:0] m;
		arst_n = 1'b0;
		pt_in.valid = 1'b0;
		pt_in.in_x = '0;
		pt_in.in_y = '0;
		pt_in.in_z = '0;
		pt_in.in_last = 1'b0;
		pt_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		cur_mode = '0;
		cur_param = '{0, 0, 0};
		cur_pivot = '{0, 0};
		cur_angle = '0;
		obj_count = 0;
		obj_sum = '{0, 0, 0};
		obj_overflow = 1'b0;
		mismatches = 0;
		hold_left = 0;
		hold_req = 0;
		hold_ack = 0;
		send_idle = 38;
		recv_idle = 75;
		phase = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// One object under reset values first: identity translation of the field extremes.
		queue_object(4, 1);
		wait_idle();
		while (phase < 11) begin
			if (phase == 4) begin
				send_idle = 75;
				recv_idle = 38;
			end else if (phase == 8) begin
				send_idle = 0;
				recv_idle = 0;
			end
			m = phase[1:0];
			write_reg(REG_MODE, {30'd0, m});
			if (phase < 4) begin
				write_reg(REG_PARAM_X, phase[0] ? 32'h7FFFFFFF : 32'h80000000);
				write_reg(REG_PARAM_Y, phase[0] ? 32'h80000000 : 32'h7FFFFFFF);
				write_reg(REG_PARAM_Z, phase[1] ? 32'h7FFFFFFF : 32'h80000000);
				write_reg(REG_PIVOT_X, phase[1] ? 32'h80000000 : 32'h7FFFFFFF);
				write_reg(REG_PIVOT_Y, phase[0] ? 32'h7FFFFFFF : 32'h80000000);
			end else begin
				write_reg(REG_PARAM_X, pick_param(m));
				write_reg(REG_PARAM_Y, pick_param(m));
				write_reg(REG_PARAM_Z, pick_param(m));
				write_reg(REG_PIVOT_X, pick_coord(0));
				write_reg(REG_PIVOT_Y, pick_coord(0));
			end
			if (phase < 8) write_reg(REG_ANGLE, angles[phase]);
			else if ($urandom_range(3) == 0) write_reg(REG_ANGLE, $urandom);
			else write_reg(REG_ANGLE, $urandom_range(0, 47185920) - 23592960);
			write_reg(REG_UNUSED, $urandom);
			if (phase == 3) begin
				queue_object(3, 1);
			end
			if (phase == 2) begin
				// Long receiver stall while points keep coming: the block must back up.
				hold_req = ~hold_req;
				queue_object(20, 0);
				queue_object(10, 0);
			end else if (phase == 5) begin
				queue_object(70, 0);
			end else if (phase == 7) begin
				queue_object(64, 0);
			end
			for (int j = 0; j < 2; j++) begin
				size = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
				queue_object(size, 0);
			end
			wait_idle();
			phase++;
		end
		if (mismatches == 0) begin
			$display("** point_set_affine_transform_core: PASSED **");
		end else begin
			$display("** point_set_affine_transform_core: FAILED **");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#4000000;
		$display("** point_set_affine_transform_core: FAILED **");
		$finish;
	end

endmodule
